### sv/welford_running_stats_defines.svh
// ----------------------------------------------------------------------------
// welford_running_stats_defines.svh
// Assertion macros shared by the running statistics block.
// ----------------------------------------------------------------------------
`ifndef WELFORD_RUNNING_STATS_DEFINES_SVH
`define WELFORD_RUNNING_STATS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared constants and control types of the running statistics block.
// ----------------------------------------------------------------------------
package wrs_pkg;

   // default widths
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF  = 16;

   // register widths and reset values
   localparam int IGNORE_W = 10;
   localparam int RUN_W    = 15;
   localparam int CSR_DATA_W = 15;
   localparam int CSR_IDX_W  = 1;
   localparam logic [IGNORE_W-1:0] IGNORE_RESET     = 10'd50;
   localparam logic [RUN_W-1:0]    RUN_LENGTH_RESET = 15'd100;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LENGTH   = 1'b1;

   // squared-deviation sum and variance widths
   localparam int M2_W  = 48;
   localparam int VAR_W = 32;
   localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

   // commands from the sequencer to each lane
   typedef struct packed {
      logic start;    // take a new sample
      logic var_req;  // finish with a variance division
      logic clear;    // end of run: clear mean and sum
   } lane_ctrl_type;

endpackage

### sv/wrs_req_if.sv
// ----------------------------------------------------------------------------
// wrs_req_if
// Sample channel: valid/ready with one energy and one magnetization sample.
// ----------------------------------------------------------------------------
interface wrs_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] energy_sample;
   logic signed [SAMPLE_WIDTH-1:0] magnet_sample;

   modport source (output valid, output energy_sample, output magnet_sample,
                   input ready);
   modport sink   (input valid, input energy_sample, input magnet_sample,
                   output ready);
endinterface

### sv/wrs_rsp_if.sv
// ----------------------------------------------------------------------------
// wrs_rsp_if
// Result channel: valid/ready with running means and end-of-run variances.
// ----------------------------------------------------------------------------
interface wrs_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] mean_energy;
   logic [SAMPLE_WIDTH-2:0]        mean_magnet;
   logic                           in_warmup;
   logic                           run_done;
   logic [31:0]                    energy_var;
   logic [31:0]                    var_magnet;

   modport source (output valid, output mean_energy, output mean_magnet,
                   output in_warmup, output run_done, output energy_var,
                   output var_magnet, input ready);
   modport sink   (input valid, input mean_energy, input mean_magnet,
                   input in_warmup, input run_done, input energy_var,
                   input var_magnet, output ready);
endinterface

### sv/wrs_lane.sv
// ----------------------------------------------------------------------------
// wrs_lane
// One Welford lane: bit-serial mean division, one multiply, saturating sum
// update and an optional bit-serial variance division.
// ----------------------------------------------------------------------------
module wrs_lane
   import wrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lane_ctrl_type                  ctrl,
   input  logic [SAMPLE_WIDTH-1:0]        sample,
   input  logic [COUNT_WIDTH:0]           count_n,
   input  logic [RUN_W-1:0]               run_len,
   output logic                           idle,
   output logic signed [SAMPLE_WIDTH-1:0] mean,
   output logic [VAR_W-1:0]               variance
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int DW      = SW + 1;
   localparam int PW      = 2 * SW;
   localparam int SUM_W   = ((PW > M2_W) ? PW : M2_W) + 1;
   localparam int REM_W   = COUNT_WIDTH + 1;
   localparam int VREM_W  = M2_W - VAR_W;
   localparam int ITER_MX = (SW > VAR_W) ? SW : VAR_W;
   localparam int CNT_W   = $clog2(ITER_MX + 1);

   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_DIV  = 3'd1;
   localparam logic [2:0] L_MEAN = 3'd2;
   localparam logic [2:0] L_MUL  = 3'd3;
   localparam logic [2:0] L_ACC  = 3'd4;
   localparam logic [2:0] L_VSET = 3'd5;
   localparam logic [2:0] L_VDIV = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]      x_ff, x_in;
   logic [REM_W-1:0]   n_ff, n_in;
   logic [DW-1:0]      delta_ff, delta_in;
   logic [SW-1:0]      quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SW-1:0]      mean_ff, mean_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [M2_W-1:0]    m2_ff, m2_in;
   logic               var_req_ff, var_req_in;
   logic [VREM_W-1:0]  vrem_ff, vrem_in;
   logic [VAR_W-1:0]   vquo_ff, vquo_in;
   logic [VAR_W-1:0]   var_ff, var_in;

   // datapath terms
   logic [DW-1:0]      start_delta, start_abs;
   logic [REM_W:0]     rem_sh;
   logic               div_ge;
   logic [DW-1:0]      delta_abs, q_ext, mean_sum;
   logic [DW-1:0]      delta2, delta2_abs;
   logic [SUM_W-1:0]   m2_sum;
   logic [VREM_W:0]    vrem_sh;
   logic               vdiv_ge;
   logic [VREM_W-1:0]  len_ext;

   always_comb begin
      // delta against the current mean, taken at sample start
      start_delta = {sample[SW-1], sample} - {mean_ff[SW-1], mean_ff};
      start_abs   = start_delta[DW-1] ? (~start_delta + DW'(1)) : start_delta;

      // one restoring step of |delta| / n
      rem_sh = {rem_ff, quo_ff[SW-1]};
      div_ge = rem_sh >= {1'b0, n_ff};

      // signed quotient added to the mean
      delta_abs = delta_ff[DW-1] ? (~delta_ff + DW'(1)) : delta_ff;
      q_ext     = {1'b0, quo_ff};
      mean_sum  = {mean_ff[SW-1], mean_ff} + (delta_ff[DW-1] ? (~q_ext + DW'(1)) : q_ext);

      // second delta against the updated mean
      delta2     = {x_ff[SW-1], x_ff} - {mean_ff[SW-1], mean_ff};
      delta2_abs = delta2[DW-1] ? (~delta2 + DW'(1)) : delta2;

      // saturating sum update
      m2_sum = SUM_W'(m2_ff) + SUM_W'(prod_ff);

      // one restoring step of M2 / run_length
      len_ext = VREM_W'(run_len);
      vrem_sh = {vrem_ff, vquo_ff[VAR_W-1]};
      vdiv_ge = vrem_sh >= {1'b0, len_ext};
   end

   // lane sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      n_in       = n_ff;
      delta_in   = delta_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      mean_in    = mean_ff;
      prod_in    = prod_ff;
      m2_in      = m2_ff;
      var_req_in = var_req_ff;
      vrem_in    = vrem_ff;
      vquo_in    = vquo_ff;
      var_in     = var_ff;
      prod_in    = delta_abs[SW-1:0] * delta2_abs[SW-1:0];
      case (state_ff)
         L_IDLE: begin
            if (ctrl.clear) begin
               mean_in = '0;
               m2_in   = '0;
            end
            if (ctrl.start) begin
               x_in       = sample;
               n_in       = count_n;
               var_req_in = ctrl.var_req;
               delta_in   = start_delta;
               quo_in     = start_abs[SW-1:0];
               rem_in     = '0;
               cnt_in     = CNT_W'(SW);
               state_in   = L_DIV;
            end
         end
         L_DIV: begin
            rem_in = div_ge ? REM_W'(rem_sh - {1'b0, n_ff}) : rem_sh[REM_W-1:0];
            quo_in = {quo_ff[SW-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = L_MEAN;
            end
         end
         L_MEAN: begin
            mean_in  = mean_sum[SW-1:0];
            state_in = L_MUL;
         end
         L_MUL: begin
            // prod_in carries |delta| * |delta2|
            state_in = L_ACC;
         end
         L_ACC: begin
            m2_in    = (m2_sum > SUM_W'(M2_MAX)) ? M2_MAX : m2_sum[M2_W-1:0];
            state_in = var_req_ff ? L_VSET : L_IDLE;
         end
         L_VSET: begin
            // quotient needs more than VAR_W bits: saturate
            if (m2_ff[M2_W-1:VAR_W] >= len_ext) begin
               var_in   = '1;
               state_in = L_IDLE;
            end else begin
               vrem_in  = m2_ff[M2_W-1:VAR_W];
               vquo_in  = m2_ff[VAR_W-1:0];
               cnt_in   = CNT_W'(VAR_W);
               state_in = L_VDIV;
            end
         end
         L_VDIV: begin
            vrem_in = vdiv_ge ? VREM_W'(vrem_sh - {1'b0, len_ext}) : vrem_sh[VREM_W-1:0];
            vquo_in = {vquo_ff[VAR_W-2:0], vdiv_ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               var_in   = {vquo_ff[VAR_W-2:0], vdiv_ge};
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         mean_ff  <= '0;
         m2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mean_ff  <= mean_in;
         m2_ff    <= m2_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      n_ff       <= n_in;
      delta_ff   <= delta_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      prod_ff    <= prod_in;
      var_req_ff <= var_req_in;
      vrem_ff    <= vrem_in;
      vquo_ff    <= vquo_in;
      var_ff     <= var_in;
   end

   assign idle     = (state_ff == L_IDLE);
   assign mean     = mean_ff;
   assign variance = var_ff;

endmodule

### sv/wrs_merge.sv
// ----------------------------------------------------------------------------
// wrs_merge
// Merges the two lanes' results into one result item and holds it in the
// output register until the transfer completes.
// ----------------------------------------------------------------------------
module wrs_merge
   import wrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           commit,
   input  logic                           warmup,
   input  logic                           done,
   input  logic signed [SAMPLE_WIDTH-1:0] mean_e,
   input  logic signed [SAMPLE_WIDTH-1:0] mean_m,
   input  logic [VAR_W-1:0]               var_e,
   input  logic [VAR_W-1:0]               var_m,
   output logic                           slot_free,
   wrs_rsp_if.source                      rsp_chan
);

   logic                           valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_e_ff;
   logic [SAMPLE_WIDTH-2:0]        mean_m_ff;
   logic                           warm_ff;
   logic                           done_ff;
   logic [VAR_W-1:0]               var_e_ff;
   logic [VAR_W-1:0]               var_m_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (commit) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload: means zero in warm-up, variances only at end of run
   always_ff @(posedge clock) begin
      if (commit) begin
         mean_e_ff <= warmup ? '0 : mean_e;
         mean_m_ff <= warmup ? '0 : mean_m[SAMPLE_WIDTH-2:0];
         warm_ff   <= warmup;
         done_ff   <= done;
         var_e_ff  <= done ? var_e : '0;
         var_m_ff  <= done ? var_m : '0;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.mean_energy = mean_e_ff;
   assign rsp_chan.mean_magnet = mean_m_ff;
   assign rsp_chan.in_warmup   = warm_ff;
   assign rsp_chan.run_done    = done_ff;
   assign rsp_chan.energy_var  = var_e_ff;
   assign rsp_chan.var_magnet  = var_m_ff;

endmodule

### sv/welford_running_stats.sv
// ----------------------------------------------------------------------------
// welford_running_stats
// Running mean and variance of energy and |magnetization| samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result. A warm-up sample
// bypasses the lanes. A counted sample goes through the bit-serial mean
// divider that each of the two lanes runs in parallel; the last sample of a
// run also starts a bit-serial variance division in each lane, which
// saturates instead when the quotient would overflow. The next sample is
// taken once the previous result has moved into the output register, where
// it may still wait. Write ignore_count and run_length
// only while no sample is in flight.
`include "welford_running_stats_defines.svh"

module welford_running_stats
   import wrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   wrs_req_if.sink               req_chan,
   wrs_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int CMP_W = ((CW > IGNORE_W) ? CW : IGNORE_W) + 1;
   localparam int LEN_W = ((CW + 1) > RUN_W) ? (CW + 1) : RUN_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [IGNORE_W-1:0] ignore_ff;
   logic [RUN_W-1:0]    run_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [1:0]          state_ff, state_in;
   logic                warm_ff, warm_in;
   logic                done_ff, done_in;

   logic                accept, commit, slot_free;
   logic                warm_now, done_now;
   logic [CMP_W-1:0]    n_wide;
   logic [CW:0]         count_n;
   logic [RUN_W-1:0]    run_len;
   logic [SW-1:0]       mag_abs;
   logic                lane_e_idle, lane_m_idle;
   logic signed [SW-1:0] mean_e, mean_m;
   logic [VAR_W-1:0]    var_e, var_m;
   lane_ctrl_type       lane_ctrl;
   logic                lanes_idle, run_end, rsp_warm, rsp_blank;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= IGNORE_RESET;
         run_ff    <= RUN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IGNORE_COUNT: ignore_ff <= csr_wr_data[IGNORE_W-1:0];
            CSR_RUN_LENGTH:   run_ff    <= csr_wr_data[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample classification
   always_comb begin
      run_len  = (run_ff == '0) ? RUN_W'(1) : run_ff;
      warm_now = CMP_W'(count_ff) < CMP_W'(ignore_ff);
      n_wide   = CMP_W'(count_ff) - CMP_W'(ignore_ff) + CMP_W'(1);
      count_n  = n_wide[CW:0];
      done_now = LEN_W'(count_n) >= LEN_W'(run_len);
   end

   // |magnetization|, most negative value saturates
   always_comb begin
      if (req_chan.magnet_sample == {1'b1, {(SW-1){1'b0}}}) begin
         mag_abs = {1'b0, {(SW-1){1'b1}}};
      end else if (req_chan.magnet_sample[SW-1]) begin
         mag_abs = ~req_chan.magnet_sample + SW'(1);
      end else begin
         mag_abs = req_chan.magnet_sample;
      end
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign commit         = (state_ff == S_FIN) && slot_free;

   always_comb begin
      lane_ctrl.start   = accept && !warm_now;
      lane_ctrl.var_req = done_now;
      lane_ctrl.clear   = commit && done_ff;
   end

   // sequencer and sample counter
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      warm_in  = warm_ff;
      done_in  = done_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               warm_in = warm_now;
               done_in = !warm_now && done_now;
               if (!warm_now && done_now) begin
                  count_in = '0;
               end else if (count_ff != '1) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = warm_now ? S_FIN : S_RUN;
            end
         end
         S_RUN: begin
            if (lane_e_idle && lane_m_idle) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         warm_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         warm_ff  <= warm_in;
         done_ff  <= done_in;
      end
   end

   // energy lane
   wrs_lane #(
      .SAMPLE_WIDTH (SW),
      .COUNT_WIDTH  (CW)
   ) u_lane_e (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .sample   (req_chan.energy_sample),
      .count_n  (count_n),
      .run_len  (run_len),
      .idle     (lane_e_idle),
      .mean     (mean_e),
      .variance (var_e)
   );

   // magnetization lane
   wrs_lane #(
      .SAMPLE_WIDTH (SW),
      .COUNT_WIDTH  (CW)
   ) u_lane_m (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lane_ctrl),
      .sample   (mag_abs),
      .count_n  (count_n),
      .run_len  (run_len),
      .idle     (lane_m_idle),
      .mean     (mean_m),
      .variance (var_m)
   );

   // result merge and output register
   wrs_merge #(
      .SAMPLE_WIDTH (SW)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .warmup    (warm_ff),
      .done      (done_ff),
      .mean_e    (mean_e),
      .mean_m    (mean_m),
      .var_e     (var_e),
      .var_m     (var_m),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   // check terms
   assign lanes_idle = lane_e_idle && lane_m_idle;
   assign run_end    = accept && !warm_now && done_now;
   assign rsp_warm   = rsp_chan.valid && rsp_chan.in_warmup;
   assign rsp_blank  = (rsp_chan.mean_energy == '0) && (rsp_chan.mean_magnet == '0)
                       && !rsp_chan.run_done;

   // checks
   `WRS_ASSERT_IMP(a_start_idle, clock, reset, lane_ctrl.start, lanes_idle, "lane busy at start")
   `WRS_ASSERT_NXT(a_commit_valid, clock, reset, commit, rsp_chan.valid, "result not presented")
   `WRS_ASSERT_NXT(a_run_end_clear, clock, reset, run_end, count_ff == '0, "count not cleared")
   `WRS_ASSERT_IMP(a_warm_zero, clock, reset, rsp_warm, rsp_blank, "warm-up result not blank")

endmodule
